// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the estimator RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/dwwe_pkg.sv
// Shared types, constants and weight-table functions of the estimator.
// No dependencies; used by the controller, the datapath and the top level.
package dwwe_pkg;

    // Fixed-point formats
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 24;
    localparam int EST_W       = 32;
    localparam int SM_W        = 32;
    localparam int SAMPLE_FRAC = 15;
    localparam int GAIN_FRAC   = 16;
    localparam int OUT_FRAC    = 24;

    // Modulating function constants
    localparam int PERIOD      = 5;
    localparam int PLANT_SCALE = 60;
    localparam int MODEL_SCALE = 30;
    localparam int POLY_COEF   = 6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] plant_sample;
        logic signed [SAMPLE_W-1:0] model_sample;
        logic signed [GAIN_W-1:0]   gain_a;
    } t_in;

    typedef struct packed {
        logic signed [EST_W-1:0] estimate;
        logic                    saturated;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic issue;
        logic round;
        logic mult;
        logic total;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic tap_last;
    } t_stat;

    // Round (a * 2^wfrac / b) to nearest, ties away from zero, by long division.
    // Evaluated at elaboration only, to build the constant weight tables.
    function automatic logic [63:0] dwwe_round_div(input logic [63:0] a,
                                                   input logic [63:0] b,
                                                   input int unsigned wfrac);
        logic [127:0] num;
        logic [127:0] quo;
        logic [64:0]  rem;
        num = {64'd0, a} << (wfrac + 1);
        quo = '0;
        rem = '0;
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return 64'((quo + 128'd1) >> 1);
    endfunction

    // Plant weight of tap k, trapezoid end taps halved
    function automatic logic [31:0] dwwe_plant_weight(input int unsigned m,
                                                      input int unsigned k,
                                                      input int unsigned wfrac);
        longint     poly;
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] w;
        poly = longint'(m) * longint'(m) - longint'(POLY_COEF) * longint'(k) * longint'(m)
             + longint'(POLY_COEF) * longint'(k) * longint'(k);
        mag  = (poly < 0) ? 64'(-poly) : 64'(poly);
        den  = 64'(PERIOD * PERIOD) * 64'(m) * 64'(m) * 64'(m);
        if (k == 0 || k == m) begin
            den = den << 1;
        end
        w = dwwe_round_div(64'(PLANT_SCALE) * mag, den, wfrac);
        return (poly < 0) ? 32'(-w) : 32'(w);
    endfunction

    // Model weight of tap k, zero at both ends
    function automatic logic [31:0] dwwe_model_weight(input int unsigned m,
                                                      input int unsigned k,
                                                      input int unsigned wfrac);
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] w;
        p   = 64'(k) * 64'(m - k);
        den = 64'(m) * 64'(m) * 64'(m) * 64'(m) * 64'(m);
        w   = dwwe_round_div(64'(MODEL_SCALE) * p * p, den, wfrac);
        return 32'(-w);
    endfunction

endpackage

// File: hw/rtl/dual_window_weighted_estimator_unit.sv
// Top level of the dual window weighted estimator: controller plus datapath.
// Depends on dwwe_pkg, dwwe_ctrl and dwwe_datapath.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------
//  in       | input     | i_in_valid / o_in_ready | i_in_data  (dwwe_pkg::t_in)
//  out      | output    | o_out_valid/ i_out_ready| o_out_data (dwwe_pkg::t_out)
//
// From acceptance of an item until its result is registered, the block sweeps one
// tap of each window per cycle through the shared multiply-accumulate lanes,
// drains the pipeline through the wait states, then rounds, multiplies by the gain
// and clips. Input is taken again the cycle after the result is registered, while
// that result still waits on the output, so no new item is taken while one is in
// flight. A stalled output holds the next result in the clip step. Reset is
// synchronous, active low; it empties both windows at once and holds input ready
// low while asserted.

module dual_window_weighted_estimator_unit #(
    parameter int WINDOW_LENGTH = 64,
    parameter int WEIGHT_BITS   = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dwwe_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dwwe_pkg::t_out o_out_data
);
    import dwwe_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequence the sweep and the handshakes
    dwwe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Hold the windows and compute the estimate
    dwwe_datapath #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_in    (i_in_data),
        .o_stat  (w_stat),
        .o_res   (o_out_data)
    );

endmodule

// File: hw/rtl/dwwe_ctrl.sv
// Controller state machine of the estimator: input and output handshakes,
// tap sweep, drain and final steps. Depends on dwwe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dwwe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  dwwe_pkg::t_stat i_stat,
    output dwwe_pkg::t_cmd  o_cmd
);
    import dwwe_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_WAIT1 = 3'd2;
    localparam logic [2:0] S_WAIT2 = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_MULT  = 3'd5;
    localparam logic [2:0] S_TOTAL = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    // Take input only when idle and out of reset
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode commands from the state
    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = o_in_ready && i_in_valid;
        o_cmd.issue = (r_state == S_RUN);
        o_cmd.round = (r_state == S_ROUND);
        o_cmd.mult  = (r_state == S_MULT);
        o_cmd.total = (r_state == S_TOTAL) && (!r_out_valid || i_out_ready);
    end

    // Advance through sweep, drain and final steps
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_RUN;
            end
            S_RUN: begin
                if (i_stat.tap_last) n_state = S_WAIT1;
            end
            S_WAIT1: n_state = S_WAIT2;
            S_WAIT2: n_state = S_ROUND;
            S_ROUND: n_state = S_MULT;
            S_MULT:  n_state = S_TOTAL;
            S_TOTAL: begin
                if (o_cmd.total) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result valid until the output transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.total) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_NEXT(a_accept_starts_run, i_in_valid && o_in_ready, r_state == S_RUN)
    `ASSERT_NEXT(a_run_holds, (r_state == S_RUN) && !i_stat.tap_last, r_state == S_RUN)
    `ASSERT_SAME(a_no_result_overwrite, o_cmd.total, !r_out_valid || i_out_ready)

endmodule

// File: hw/rtl/dwwe_datapath.sv
// Datapath of the estimator: sample windows, weight tables, two MAC lanes,
// rounding, gain product and saturation. Depends on dwwe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dwwe_datapath #(
    parameter int WINDOW_LENGTH = 64,
    parameter int WEIGHT_BITS   = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dwwe_pkg::t_cmd  i_cmd,
    input  dwwe_pkg::t_in   i_in,
    output dwwe_pkg::t_stat o_stat,
    output dwwe_pkg::t_out  o_res
);
    import dwwe_pkg::*;

    localparam int IDX_W   = $clog2(WINDOW_LENGTH);
    localparam int FILL_W  = $clog2(WINDOW_LENGTH + 1);
    localparam int WFRAC   = WEIGHT_BITS - 2;
    localparam int SHIFT   = SAMPLE_FRAC + WFRAC - OUT_FRAC;
    localparam int MUL_W   = SAMPLE_W + WEIGHT_BITS;
    localparam int ACC_W   = MUL_W + IDX_W;
    localparam int SUM_W   = ACC_W + 1;
    localparam int GP_W    = GAIN_W + SM_W;
    localparam int GX_W    = GP_W + 1;
    localparam int TOT_W   = ((SUM_W > GX_W) ? SUM_W : GX_W) + 1;
    localparam int unsigned M_LAST = WINDOW_LENGTH - 1;

    localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(WINDOW_LENGTH - 1);
    localparam logic [FILL_W-1:0]       FILL_MAX = FILL_W'(WINDOW_LENGTH);
    localparam logic signed [SUM_W-1:0] RND_SUM  = {{(SUM_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
    localparam logic signed [GX_W-1:0]  RND_GAIN = {{(GX_W-1){1'b0}}, 1'b1} << (GAIN_FRAC - 1);
    localparam logic signed [TOT_W-1:0] EST_MAX  = {{(TOT_W-EST_W+1){1'b0}}, {(EST_W-1){1'b1}}};
    localparam logic signed [TOT_W-1:0] EST_MIN  = {{(TOT_W-EST_W+1){1'b1}}, {(EST_W-1){1'b0}}};

    // Constant weight tables
    logic signed [WEIGHT_BITS-1:0] w_pw_tab [WINDOW_LENGTH];
    logic signed [WEIGHT_BITS-1:0] w_mw_tab [WINDOW_LENGTH];

    for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_tab
        assign w_pw_tab[g] = WEIGHT_BITS'(dwwe_plant_weight(M_LAST, g, WFRAC));
        assign w_mw_tab[g] = WEIGHT_BITS'(dwwe_model_weight(M_LAST, g, WFRAC));
    end

    // Sample windows
    logic signed [SAMPLE_W-1:0] r_mem_p [WINDOW_LENGTH];
    logic signed [SAMPLE_W-1:0] r_mem_m [WINDOW_LENGTH];

    logic [IDX_W-1:0]  r_wr_idx;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  r_tap;
    logic [FILL_W-1:0] r_fill;
    logic [IDX_W-1:0]  w_wr_next;
    logic [IDX_W-1:0]  w_rd_next;

    logic                          r_v1;
    logic                          r_v2;
    logic                          r_ok1;
    logic signed [SAMPLE_W-1:0]    r_ps_raw;
    logic signed [SAMPLE_W-1:0]    r_ms_raw;
    logic signed [WEIGHT_BITS-1:0] r_pw;
    logic signed [WEIGHT_BITS-1:0] r_mw;
    logic signed [SAMPLE_W-1:0]    w_ps;
    logic signed [SAMPLE_W-1:0]    w_ms;
    logic signed [MUL_W-1:0]       r_pp;
    logic signed [MUL_W-1:0]       r_mp;
    logic signed [ACC_W-1:0]       r_acc_p;
    logic signed [ACC_W-1:0]       r_acc_m;
    logic signed [GAIN_W-1:0]      r_gain;

    logic signed [SUM_W-1:0] w_sp_sum;
    logic signed [SUM_W-1:0] w_sp_rnd;
    logic signed [SUM_W-1:0] w_sm_sum;
    logic signed [SUM_W-1:0] w_sm_rnd;
    logic signed [SUM_W-1:0] r_sp;
    logic signed [SM_W-1:0]  r_sm;
    logic signed [GP_W-1:0]  r_prod;
    logic signed [GX_W-1:0]  w_g_sum;
    logic signed [GX_W-1:0]  w_g_rnd;
    logic signed [TOT_W-1:0] w_tot;
    t_out                    r_res;
    t_out                    w_res;

    assign w_wr_next = (r_wr_idx == IDX_LAST) ? '0 : r_wr_idx + 1'b1;
    assign w_rd_next = (r_rd_idx == IDX_LAST) ? '0 : r_rd_idx + 1'b1;

    assign o_stat.tap_last = (r_tap == IDX_LAST);

    // Write new samples, read one tap per issue cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem_p[r_wr_idx] <= i_in.plant_sample;
            r_mem_m[r_wr_idx] <= i_in.model_sample;
        end
        if (i_cmd.issue) begin
            r_ps_raw <= r_mem_p[r_rd_idx];
            r_ms_raw <= r_mem_m[r_rd_idx];
        end
    end

    // Window pointers, fill count and pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_tap    <= '0;
            r_fill   <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.load) begin
                r_wr_idx <= w_wr_next;
                r_rd_idx <= w_wr_next;
                r_tap    <= '0;
                if (r_fill != FILL_MAX) r_fill <= r_fill + 1'b1;
            end else if (i_cmd.issue) begin
                r_rd_idx <= w_rd_next;
                r_tap    <= r_tap + 1'b1;
            end
        end
    end

    // Slots never written read as zero
    assign w_ps = r_ok1 ? r_ps_raw : '0;
    assign w_ms = r_ok1 ? r_ms_raw : '0;

    // Weight fetch, multiply and accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gain <= i_in.gain_a;
        end
        if (i_cmd.issue) begin
            r_pw  <= w_pw_tab[r_tap];
            r_mw  <= w_mw_tab[r_tap];
            r_ok1 <= (FILL_W'(r_rd_idx) < r_fill);
        end
        r_pp <= w_ps * r_pw;
        r_mp <= w_ms * r_mw;
        if (i_cmd.load) begin
            r_acc_p <= '0;
            r_acc_m <= '0;
        end else if (r_v2) begin
            r_acc_p <= r_acc_p + ACC_W'(r_pp);
            r_acc_m <= r_acc_m + ACC_W'(r_mp);
        end
    end

    // Round both sums to the output fraction
    always_comb begin
        w_sp_sum = SUM_W'(r_acc_p) + RND_SUM;
        w_sp_rnd = w_sp_sum >>> SHIFT;
        w_sm_sum = SUM_W'(r_acc_m) + RND_SUM;
        w_sm_rnd = w_sm_sum >>> SHIFT;
    end

    // Round the gain product, add and clip
    always_comb begin
        w_g_sum = GX_W'(r_prod) + RND_GAIN;
        w_g_rnd = w_g_sum >>> GAIN_FRAC;
        w_tot   = TOT_W'(r_sp) + TOT_W'(w_g_rnd);
        priority if (w_tot > EST_MAX) begin
            w_res.estimate  = EST_MAX[EST_W-1:0];
            w_res.saturated = 1'b1;
        end else if (w_tot < EST_MIN) begin
            w_res.estimate  = EST_MIN[EST_W-1:0];
            w_res.saturated = 1'b1;
        end else begin
            w_res.estimate  = w_tot[EST_W-1:0];
            w_res.saturated = 1'b0;
        end
    end

    // Final steps and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            r_sp <= w_sp_rnd;
            r_sm <= w_sm_rnd[SM_W-1:0];
        end
        if (i_cmd.mult) begin
            r_prod <= r_gain * r_sm;
        end
        if (i_cmd.total) begin
            r_res <= w_res;
        end
    end

    assign o_res = r_res;

    `ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FILL_MAX)
    `ASSERT_SAME(a_wr_idx_bound, 1'b1, r_wr_idx <= IDX_LAST)
    `ASSERT_NEXT(a_issue_to_mac, i_cmd.issue, r_v1 && !i_cmd.round)

endmodule

// File: tb/sv/dual_window_weighted_estimator_unit_test.sv
// Self-checking testbench for dual_window_weighted_estimator_unit: drives samples, predicts
// each estimate from its own sliding windows and weight tables, and checks every result.
// Depends on dwwe_pkg and the estimator RTL.
module dual_window_weighted_estimator_unit_test;

    localparam int WIN       = 64;
    localparam int WBITS     = 24;
    localparam int WFRAC     = WBITS - 2;
    localparam int SUM_SHIFT = dwwe_pkg::SAMPLE_FRAC + WFRAC - dwwe_pkg::OUT_FRAC;
    localparam longint EST_MAX = (longint'(1) <<< 31) - 1;
    localparam longint EST_MIN = -(longint'(1) <<< 31);
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 1500;
    localparam int RANDOM_ITEMS = 630;

    // Scoreboard: shadow windows, weight tables and the queue of pending estimates
    class estimate_checker;
        logic signed [15:0] plant_hist [WIN];
        logic signed [15:0] model_hist [WIN];
        longint             plant_wt [WIN];
        longint             model_wt [WIN];
        int unsigned        wr_slot;
        dwwe_pkg::t_out     expected_estimates [$];
        int unsigned        n_fail;
        int unsigned        n_checked;

        // round(num * 2^WFRAC / den), ties away from zero
        function longint unsigned round_ratio(longint unsigned num, longint unsigned den);
            longint unsigned q;
            q = (num << (WFRAC + 1)) / den;
            return (q + 1) >> 1;
        endfunction

        // Drop s fraction bits: add half, then floor
        function longint round_drop(longint x, int s);
            return (x + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function new();
            longint          m;
            longint          poly;
            longint          p;
            longint unsigned mag;
            longint unsigned den;
            longint unsigned w;
            m = WIN - 1;
            for (int k = 0; k < WIN; k++) begin
                poly = m * m - dwwe_pkg::POLY_COEF * k * m + dwwe_pkg::POLY_COEF * k * k;
                mag  = (poly < 0) ? -poly : poly;
                den  = dwwe_pkg::PERIOD * dwwe_pkg::PERIOD * m * m * m;
                // trapezoid end taps carry half weight
                if (k == 0 || k == m) begin
                    den = den * 2;
                end
                w = round_ratio(dwwe_pkg::PLANT_SCALE * mag, den);
                plant_wt[k] = (poly < 0) ? -longint'(w) : longint'(w);
                p = k * (m - k);
                w = round_ratio(dwwe_pkg::MODEL_SCALE * p * p, m * m * m * m * m);
                model_wt[k] = -longint'(w);
                plant_hist[k] = '0;
                model_hist[k] = '0;
            end
            wr_slot   = 0;
            n_fail    = 0;
            n_checked = 0;
        endfunction

        function void report_mismatch(string what);
            n_fail++;
            $display("mismatch: %s", what);
        endfunction

        // Push the accepted samples and queue the estimate they produce
        function void predict_estimate(dwwe_pkg::t_in item);
            longint         plant_sum;
            longint         model_sum;
            longint         total;
            int unsigned    idx;
            dwwe_pkg::t_out want;
            plant_hist[wr_slot] = item.plant_sample;
            model_hist[wr_slot] = item.model_sample;
            wr_slot = (wr_slot + 1) % WIN;
            plant_sum = 0;
            model_sum = 0;
            idx = wr_slot;
            // tap 0 is the oldest sample
            for (int i = 0; i < WIN; i++) begin
                plant_sum += longint'(plant_hist[idx]) * plant_wt[i];
                model_sum += longint'(model_hist[idx]) * model_wt[i];
                idx = (idx + 1) % WIN;
            end
            plant_sum = round_drop(plant_sum, SUM_SHIFT);
            model_sum = round_drop(model_sum, SUM_SHIFT);
            total = plant_sum + round_drop(longint'(item.gain_a) * model_sum,
                                           dwwe_pkg::GAIN_FRAC);
            want.saturated = 1'b0;
            if (total > EST_MAX) begin
                total = EST_MAX;
                want.saturated = 1'b1;
            end
            if (total < EST_MIN) begin
                total = EST_MIN;
                want.saturated = 1'b1;
            end
            want.estimate = total[31:0];
            expected_estimates.push_back(want);
        endfunction

        function void check_estimate(dwwe_pkg::t_out got);
            dwwe_pkg::t_out want;
            n_checked++;
            if (expected_estimates.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none pending", n_checked));
                return;
            end
            want = expected_estimates.pop_front();
            if (got.estimate !== want.estimate) begin
                report_mismatch($sformatf("result %0d estimate got %0d want %0d",
                                          n_checked, got.estimate, want.estimate));
            end
            if (got.saturated !== want.saturated) begin
                report_mismatch($sformatf("result %0d saturated got %0b want %0b",
                                          n_checked, got.saturated, want.saturated));
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    dwwe_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    dwwe_pkg::t_out o_out_data;

    estimate_checker checker_h;
    int              burst_left;

    dual_window_weighted_estimator_unit #(
        .WINDOW_LENGTH (WIN),
        .WEIGHT_BITS   (WBITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run as a failure if it has not finished by the time limit
    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    function automatic dwwe_pkg::t_in make_item(logic [15:0] plant, logic [15:0] model,
                                                logic [23:0] gain);
        dwwe_pkg::t_in item;
        item.plant_sample = plant;
        item.model_sample = model;
        item.gain_a       = gain;
        return item;
    endfunction

    // Offer one transaction and hold it until the block takes it
    task automatic offer_sample(input dwwe_pkg::t_in item);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        checker_h.predict_estimate(item);
    endtask

    // Advance the burst; drop valid for a random gap when it runs out
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 90);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic send_paced(input dwwe_pkg::t_in item);
        offer_sample(item);
        pace_sender();
    endtask

    // Extremes of every field; the windows are still warming up here
    task automatic run_directed();
        send_paced(make_item(16'sd0, 16'sd0, 24'sd0));
        send_paced(make_item(16'sh7fff, 16'sd0, 24'sd0));
        send_paced(make_item(16'sh8000, 16'sd0, 24'sd0));
        send_paced(make_item(16'sd0, 16'sh7fff, 24'sh7fffff));
        send_paced(make_item(16'sd0, 16'sh8000, 24'sh800000));
        send_paced(make_item(16'sh8000, 16'sh8000, 24'sh800000));
        send_paced(make_item(16'sh7fff, 16'sh7fff, 24'sh7fffff));
        send_paced(make_item(16'sd1, 16'sh7fff, 24'sd1));
        send_paced(make_item(16'shffff, 16'sh8000, 24'shffffff));
        send_paced(make_item(16'sd1, 16'shffff, 24'sd65536));
        send_paced(make_item(16'sh5555, 16'shaaaa, 24'sh555555));
        send_paced(make_item(16'shaaaa, 16'sh5555, 24'shaaaaaa));
        send_paced(make_item(16'sh7fff, 16'sh8000, 24'sh7fffff));
        send_paced(make_item(16'sh8000, 16'sh7fff, 24'sh800000));
        send_paced(make_item(16'sd0, 16'sh8000, 24'sh7fffff));
        send_paced(make_item(16'sd0, 16'sh8000, 24'sh800000));
        send_paced(make_item(16'sd0, 16'sd0, 24'sh7fffff));
        send_paced(make_item(16'sh8000, 16'sh8000, 24'sd0));
    endtask

    // Random segments: noise, clipping runs, small values and constant runs
    task automatic run_random(input int target);
        int            sent;
        int            kind;
        int            len;
        logic [15:0]   model_ext;
        logic [23:0]   gain_ext;
        dwwe_pkg::t_in item;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 3);
            len  = $urandom_range(1, 40);
            model_ext = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
            case ($urandom_range(0, 2))
                0: gain_ext = 24'sh7fffff;
                1: gain_ext = 24'sh800000;
                default: gain_ext = $urandom_range(0, 1) ? 24'(32'h7fffff - $urandom_range(0, 4095))
                                                         : 24'(32'h800000 + $urandom_range(0, 4095));
            endcase
            if (kind == 1) begin
                // a full window of extreme model samples drives the total to the limits
                len = $urandom_range(64, 100);
            end
            item = make_item(16'($urandom), 16'($urandom), 24'($urandom));
            for (int j = 0; j < len && sent < target; j++) begin
                case (kind)
                    0: item = make_item(16'($urandom), 16'($urandom), 24'($urandom));
                    1: item = make_item(16'($urandom), model_ext, gain_ext);
                    2: item = make_item(16'($urandom_range(0, 127)) - 16'd64,
                                        16'($urandom_range(0, 127)) - 16'd64,
                                        24'($urandom));
                    default: ;
                endcase
                send_paced(item);
                sent++;
            end
        end
    endtask

    // Receiver: rotate through stall patterns, with one long hold-off
    initial begin
        int unsigned cyc;
        int unsigned hold_left;
        bit          hold_done;
        cyc       = 0;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                checker_h.check_estimate(o_out_data);
            end
            if (!i_rst_n) begin
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && checker_h.n_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                cyc++;
                case ((cyc / 150) % 4)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= $urandom_range(0, 1);
                    default: i_out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Main sequence: reset, directed, random, drain, verdict
    initial begin
        checker_h  = new();
        burst_left = 5;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(RANDOM_ITEMS);
        i_in_valid <= 1'b0;
        while (checker_h.expected_estimates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (WIN + 16) @(posedge i_clk);
        if (checker_h.n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
